### src/lurt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lurt_pkg;

	// alphabet and field widths
	localparam int ALPHABET_SIZE = 256;
	localparam int SYM_W         = 8;
	localparam int CNT_W         = 9;

	// one cell per possible window slot
	localparam int NUM_CELLS  = ALPHABET_SIZE;
	localparam int CELL_W     = $clog2(NUM_CELLS);
	localparam int GROUP_SIZE = 16;
	localparam int NUM_GROUPS = (NUM_CELLS + GROUP_SIZE - 1) / GROUP_SIZE;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_UPDATE
	} state_t;

	// outcome of the search along the chain
	typedef struct packed {
		logic              hit;
		logic [CELL_W-1:0] pos;
	} match_res_t;

endpackage
`default_nettype wire

### src/lurt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module lurt_cell
	import lurt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             shift,
	input  wire logic [SYM_W-1:0] byte_in,
	input  wire logic [SYM_W-1:0] probe,
	input  wire logic             live,
	output logic      [SYM_W-1:0] byte_out,
	output logic                  hit
);

	logic [SYM_W-1:0] byte_q;

	// slot content, handed on to the older neighbour on each shift
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;

	// compare against the incoming byte, only inside the window
	assign hit = live && (byte_q == probe);

endmodule
`default_nettype wire

### src/lurt_match_enc.sv
`timescale 1ns / 1ps
`default_nettype none
module lurt_match_enc
	import lurt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic [NUM_CELLS-1:0] hits,
	output match_res_t                res
);

	logic              grp_hit_d  [NUM_GROUPS];
	logic [CELL_W-1:0] grp_pos_d  [NUM_GROUPS];
	logic              grp_hit_s1 [NUM_GROUPS];
	logic [CELL_W-1:0] grp_pos_s1 [NUM_GROUPS];

	// first level: or-encode each group of cells (at most one hit in the window)
	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_hit_d[g] = 1'b0;
			grp_pos_d[g] = '0;
			for (int j = 0; j < GROUP_SIZE; j++) begin
				if (g * GROUP_SIZE + j < NUM_CELLS) begin
					if (hits[g * GROUP_SIZE + j]) begin
						grp_hit_d[g] = 1'b1;
						grp_pos_d[g] = grp_pos_d[g] | CELL_W'(g * GROUP_SIZE + j);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_hit_s1[g] <= grp_hit_d[g];
			grp_pos_s1[g] <= grp_pos_d[g];
		end
	end

	// second level: merge the group results
	always_comb begin
		res = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			res.hit = res.hit | grp_hit_s1[g];
			res.pos = res.pos | grp_pos_s1[g];
		end
	end

endmodule
`default_nettype wire

### src/longest_unique_run_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// input    | in_valid / in_stall  | symbol, last_of_string
// output   | out_valid / out_stall| best_length, window_length, is_final
//
// Per byte, a compare step checks the byte against every cell of the window
// chain and registers the group hits, then an update step merges them, shifts
// the chain and loads the output register.
// The next byte is taken in the cycle the previous result is loaded.
// Reset clears the window length and best length; cell contents need none.
// A stalled output holds the unit in the update step until the beat leaves.
module longest_unique_run_tracker_unit
	import lurt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [SYM_W-1:0] symbol,
	input  wire logic             last_of_string,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [CNT_W-1:0] best_length,
	output logic      [CNT_W-1:0] window_length,
	output logic                  is_final
);

	state_t state_q, state_d;

	logic             in_acc;
	logic             can_out;
	logic             shift;
	logic [SYM_W-1:0] sym_map;
	logic [SYM_W-1:0] sym_q;
	logic             fin_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] best_q;
	logic [CNT_W-1:0] new_count;
	logic [CNT_W-1:0] new_best;
	logic             out_valid_q;
	logic [CNT_W-1:0] best_out_q;
	logic [CNT_W-1:0] win_out_q;
	logic             fin_out_q;

	logic [SYM_W-1:0]     chain [NUM_CELLS+1];
	logic [NUM_CELLS-1:0] live;
	logic [NUM_CELLS-1:0] hits;
	match_res_t           mres;

	// symbols beyond the alphabet fold onto its top value
	assign sym_map = ({1'b0, symbol} >= CNT_W'(ALPHABET_SIZE))
		? SYM_W'(ALPHABET_SIZE - 1) : symbol;

	assign can_out = !out_valid_q || !out_stall;
	assign in_acc  = in_valid && !in_stall;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		shift    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (can_out) begin
					shift    = 1'b1;
					in_stall = 1'b0;
					state_d  = in_valid ? ST_MATCH : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// input beat capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sym_q <= sym_map;
			fin_q <= last_of_string;
		end
	end

	// chain of window cells, youngest byte in cell zero
	assign chain[0] = sym_q;

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		assign live[i] = CNT_W'(i) < count_q;

		lurt_cell u_cell (
			.clk      (clk),
			.shift    (shift),
			.byte_in  (chain[i]),
			.probe    (sym_q),
			.live     (live[i]),
			.byte_out (chain[i+1]),
			.hit      (hits[i])
		);
	end

	lurt_match_enc u_enc (
		.clk  (clk),
		.hits (hits),
		.res  (mres)
	);

	// a repeat cuts the window just past the earlier copy
	assign new_count = mres.hit ? (CNT_W'(mres.pos) + CNT_W'(1)) : (count_q + CNT_W'(1));
	assign new_best  = (new_count > best_q) ? new_count : best_q;

	// window and best length, cleared after the last byte of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			best_q  <= '0;
		end else if (shift) begin
			if (fin_q) begin
				count_q <= '0;
				best_q  <= '0;
			end else begin
				count_q <= new_count;
				best_q  <= new_best;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (shift) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			best_out_q <= new_best;
			win_out_q  <= new_count;
			fin_out_q  <= fin_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign best_length   = best_out_q;
	assign window_length = win_out_q;
	assign is_final      = fin_out_q;

`ifndef SYNTH
	// window never outgrows the chain
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(NUM_CELLS))
		else $error("window length beyond chain depth");

	// best length covers the current window
	a_best_covers: assert property (@(posedge clk) disable iff (!arst_n)
		best_q >= count_q)
		else $error("best length below window length");

	// every result carries a non-empty window no longer than the best
	a_out_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (window_length != '0) && (window_length <= best_length))
		else $error("result lengths inconsistent");

	// the compare step follows an accepted beat
	a_match_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MATCH) |-> $past(in_acc))
		else $error("compare step without an accepted beat");

	// a shift clears the string state after a final beat
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(shift && fin_q) |=> (count_q == '0) && (best_q == '0))
		else $error("state not cleared after final beat");
`endif

endmodule
`default_nettype wire

### tb/run_length_checker.sv
`timescale 1ns / 1ps
module run_length_checker
	import lurt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_stall,
	input  wire logic [SYM_W-1:0] symbol,
	input  wire logic             last_of_string,
	input  wire logic             out_valid,
	input  wire logic             out_stall,
	input  wire logic [CNT_W-1:0] best_length,
	input  wire logic [CNT_W-1:0] window_length,
	input  wire logic             is_final,
	output int                    mismatches,
	output int                    pending,
	output int                    compared,
	output int                    widest
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [CNT_W-1:0] best;
		logic [CNT_W-1:0] window;
		logic             fin;
	} run_result_t;

	// expected beats, oldest first
	run_result_t expected_runs[$];

	// mirrored window state
	logic [ALPHABET_SIZE-1:0] in_window;
	logic [SYM_W-1:0]         ring_bytes [ALPHABET_SIZE];
	logic [SYM_W-1:0]         oldest_slot;
	logic [CNT_W-1:0]         held_count;
	logic [CNT_W-1:0]         best_run;

	// back to an empty window for the next string
	task automatic clear_window();
		in_window   = '0;
		oldest_slot = '0;
		held_count  = '0;
		best_run    = '0;
	endtask

	// slide the window over one byte and queue the beat it should produce
	task automatic advance_window(input logic [SYM_W-1:0] raw, input logic fin);
		logic [SYM_W-1:0] sym;
		logic [SYM_W-1:0] leaving;
		logic [SYM_W-1:0] slot;
		run_result_t      res;
		sym = raw;
		// values past the alphabet fold onto its top value
		if (int'(sym) >= ALPHABET_SIZE)
			sym = SYM_W'(ALPHABET_SIZE - 1);
		// drop from the start until the earlier copy has gone
		while (in_window[sym] && held_count != 0) begin
			leaving            = ring_bytes[oldest_slot];
			in_window[leaving] = 1'b0;
			oldest_slot        = oldest_slot + 1'b1;
			held_count         = held_count - 1'b1;
		end
		if (held_count < ALPHABET_SIZE) begin
			slot             = oldest_slot + held_count[SYM_W-1:0];
			ring_bytes[slot] = sym;
			held_count       = held_count + 1'b1;
		end
		in_window[sym] = 1'b1;
		if (held_count > best_run)
			best_run = held_count;
		if (int'(held_count) > widest)
			widest = int'(held_count);
		res.best   = best_run;
		res.window = held_count;
		res.fin    = fin;
		expected_runs.push_back(res);
		if (fin)
			clear_window();
	endtask

	// compare one output beat with the oldest expectation
	task automatic check_result();
		run_result_t want;
		if (expected_runs.size() == 0) begin
			if (mismatches < REPORT_LIMIT)
				$display("%0t: unexpected beat best=%0d window=%0d final=%0b",
					$realtime, best_length, window_length, is_final);
			mismatches++;
		end else begin
			want = expected_runs.pop_front();
			compared++;
			if (best_length !== want.best || window_length !== want.window ||
					is_final !== want.fin) begin
				if (mismatches < REPORT_LIMIT)
					$display("%0t: mismatch best %0d/%0d window %0d/%0d final %0b/%0b (exp/got)",
						$realtime, want.best, best_length, want.window, window_length,
						want.fin, is_final);
				mismatches++;
			end
		end
	endtask

	// watch both channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_window();
			expected_runs.delete();
			mismatches = 0;
			pending    = 0;
			compared   = 0;
			widest     = 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				advance_window(symbol, last_of_string);
			pending = expected_runs.size();
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top
	import lurt_pkg::*;
();

	localparam int CYCLE_LIMIT  = 300000;
	localparam int PHASE_BYTES  = 60;
	localparam int DRAIN_CYCLES = 8;
	localparam int NUM_DIRECTED = 22;

	logic             clk            = 1'b1;
	logic             arst_n         = 1'b0;
	logic             in_valid       = 1'b0;
	logic             in_stall;
	logic [SYM_W-1:0] symbol         = '0;
	logic             last_of_string = 1'b0;
	logic             out_valid;
	logic             out_stall      = 1'b0;
	logic [CNT_W-1:0] best_length;
	logic [CNT_W-1:0] window_length;
	logic             is_final;

	int send_pct     = 0;
	int recv_pct     = 0;
	int cycles       = 0;
	int strings_sent = 0;
	int bytes_sent   = 0;
	int mismatches;
	int pending;
	int compared;
	int widest;

	// short strings covering single bytes, repeats and the field extremes
	logic [SYM_W-1:0] directed_bytes [NUM_DIRECTED] = '{
		8'h00,
		8'hff,
		8'h55, 8'h55,
		8'h00, 8'hff, 8'h00, 8'haa, 8'h55,
		8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63, 8'h62, 8'h62,
		8'h80, 8'h7f, 8'h01, 8'hfe, 8'h80
	};
	logic directed_last [NUM_DIRECTED] = '{
		1'b1,
		1'b1,
		1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b1
	};

	longest_unique_run_tracker_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.symbol         (symbol),
		.last_of_string (last_of_string),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.best_length    (best_length),
		.window_length  (window_length),
		.is_final       (is_final)
	);

	run_length_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.symbol         (symbol),
		.last_of_string (last_of_string),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.best_length    (best_length),
		.window_length  (window_length),
		.is_final       (is_final),
		.mismatches     (mismatches),
		.pending        (pending),
		.compared       (compared),
		.widest         (widest)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b0;
		#1 clk = 1'b1;
	end

	// random back-pressure on the result side
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_pct);
	end

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// offer one byte, with random gaps ahead of it, until it is taken
	task automatic send_byte(input logic [SYM_W-1:0] sym, input logic fin);
		while ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		symbol         <= sym;
		last_of_string <= fin;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		bytes_sent++;
		if (fin)
			strings_sent++;
		@(negedge clk);
	endtask

	// hold off the sender until every result is back
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	// short string drawn either from all bytes or from a small pool, so repeats are common
	task automatic send_random_string();
		logic [SYM_W-1:0] pool [16];
		logic [SYM_W-1:0] sym;
		int               len;
		int               pool_n;
		logic             wide;
		len    = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
		wide   = ($urandom_range(0, 3) == 0);
		pool_n = $urandom_range(2, 16);
		for (int i = 0; i < pool_n; i++)
			pool[i] = SYM_W'($urandom_range(0, 255));
		for (int i = 0; i < len; i++) begin
			sym = wide ? SYM_W'($urandom_range(0, 255)) : pool[$urandom_range(0, pool_n - 1)];
			send_byte(sym, i == len - 1);
		end
	endtask

	// every byte value once in shuffled order fills the window, then a few repeats
	task automatic send_full_alphabet();
		logic [SYM_W-1:0] order [ALPHABET_SIZE];
		logic [SYM_W-1:0] swap;
		int               j;
		int               extra;
		for (int i = 0; i < ALPHABET_SIZE; i++)
			order[i] = SYM_W'(i);
		for (int i = ALPHABET_SIZE - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			swap     = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		extra = $urandom_range(1, 6);
		for (int i = 0; i < ALPHABET_SIZE; i++)
			send_byte(order[i], 1'b0);
		for (int i = 0; i < extra; i++)
			send_byte(SYM_W'($urandom_range(0, 255)), i == extra - 1);
	endtask

	// stimulus and verdict
	initial begin
		int phase_start;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed strings
		for (int i = 0; i < NUM_DIRECTED; i++)
			send_byte(directed_bytes[i], directed_last[i]);
		wait_for_drain();

		// random strings under three idling mixes
		for (int phase = 0; phase < 3; phase++) begin
			send_pct = (phase == 0) ? 37 : (phase == 1) ? 49 : 0;
			recv_pct = (phase == 0) ? 49 : (phase == 1) ? 37 : 0;
			phase_start = bytes_sent;
			if (phase == 1)
				send_full_alphabet();
			while (bytes_sent - phase_start < PHASE_BYTES)
				send_random_string();
			wait_for_drain();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d strings of %0d bytes, %0d results compared, widest window %0d",
			strings_sent, bytes_sent, compared, widest);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
